### rtl/core/pcr_pkg.sv
package pcr_pkg;

  // configuration register width and register indexes
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 12'd320;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  localparam int PIX_W = 32;
  localparam int DEST_W = 22;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB888 = 2'd1,
    FMT_ARGB   = 2'd2
  } pix_fmt_e;

  // position of one pixel in the rotated image, split for a late add
  typedef struct packed {
    logic [DEST_W-1:0] col_offset;
    logic [DEST_W-1:0] rev_row;
    logic              frame_end;
  } pos_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } rgb_t;

  localparam logic [7:0] FULL_SCALE = 8'd255;

endpackage

### rtl/core/pixel_convert_rotate90.sv
// Pixel format converter with 90 degree rotation index. Takes framebuffer
// pixels in raster order (row 0 first, left to right), one per transaction,
// and gives three bytes per pixel plus the pixel's index in the rotated
// image, column*height + (height-1-row), and a flag on the last pixel of the
// frame. RGB565 channels are scaled to 8 bits as 255*c/32 (red, blue) and
// 255*c/64 (green); the 24-bit and 32-bit formats pass the low three bytes
// and drop alpha. One pixel is accepted every clock while in_stall_o is low;
// a pixel passes the input register, then the result register, and the
// pipeline holds up to two pixels while the output is stalled. Width and
// height of zero act as one and are capped at MAX_WIDTH / MAX_HEIGHT.
// Writing frame_width or frame_height restarts the raster at row 0, column
// 0; writing pixel_format keeps the position. Write configuration only while
// no transaction is in flight.
module pixel_convert_rotate90 #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcr_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcr_pkg::PIX_W-1:0]     pixel_word_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcr_pkg::DEST_W-1:0]    dest_index_o,
  output logic [pcr_pkg::BYTE_W-1:0]    byte_zero_o,
  output logic [pcr_pkg::BYTE_W-1:0]    byte_one_o,
  output logic [pcr_pkg::BYTE_W-1:0]    byte_two_o,
  output logic                          frame_end_o
);
  import pcr_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_WW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CMP_HW = (HW > CFG_W) ? HW : CFG_W;

  // configuration registers
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  pix_fmt_e         pixel_format_q;

  // clamped geometry
  logic [CMP_WW-1:0] width_ext;
  logic [CMP_HW-1:0] height_ext;
  logic [WW-1:0]     width_eff;
  logic [HW-1:0]     height_eff;

  // pipeline control
  logic in_accept, s2_ready, restart;
  logic s1_valid_q, out_valid_q;

  // stage payloads
  logic [PIX_W-1:0]  s1_pixel_q;
  pos_t              s1_pos_q;
  pos_t              pos;
  rgb_t              rgb;
  logic [DEST_W-1:0] dest_d, dest_q;
  rgb_t              rgb_q;
  logic              frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      pixel_format_q <= FMT_RGB565;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        REG_PIXEL_FORMAT: pixel_format_q <= pix_fmt_e'(cfg_data_i[1:0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // geometry write restarts the raster
  assign restart = cfg_we_i &&
                   (cfg_idx_i == REG_FRAME_WIDTH || cfg_idx_i == REG_FRAME_HEIGHT);

  // zero acts as one, oversize saturates
  assign width_ext = CMP_WW'(frame_width_q);
  assign height_ext = CMP_HW'(frame_height_q);
  assign width_eff = (width_ext == '0) ? WW'(1) :
                     (width_ext > CMP_WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ext);
  assign height_eff = (height_ext == '0) ? HW'(1) :
                      (height_ext > CMP_HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ext);

  // two-register pipeline, each stage moves when the one after it has room
  assign s2_ready = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_accept = in_valid_i && !in_stall_o;

  // raster counters, sampled into the input register on each accepted pixel
  pcr_geom #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .restart_i(restart),
    .advance_i(in_accept),
    .width_i  (width_eff),
    .height_i (height_eff),
    .pos_o    (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!s1_valid_q || s2_ready) begin
        s1_valid_q <= in_accept;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // input register, payload only
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pixel_q <= pixel_word_i;
      s1_pos_q <= pos;
    end
  end

  // conversion and index add between the two registers
  pcr_convert u_convert (
    .pixel_i(s1_pixel_q),
    .fmt_i  (pixel_format_q),
    .rgb_o  (rgb)
  );

  assign dest_d = s1_pos_q.col_offset + s1_pos_q.rev_row;

  // result register
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      dest_q <= dest_d;
      rgb_q <= rgb;
      frame_end_q <= s1_pos_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dest_index_o = dest_q;
  assign byte_zero_o = rgb_q.b0;
  assign byte_one_o = rgb_q.b1;
  assign byte_two_o = rgb_q.b2;
  assign frame_end_o = frame_end_q;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while pipeline has room");
  a_out_held_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o &&
      $stable({dest_index_o, byte_zero_o, byte_one_o, byte_two_o, frame_end_o})))
    else $error("stalled result dropped or changed");
  a_input_reg_kept_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("input register lost a pixel while stalled");
`endif

endmodule

### rtl/core/pcr_geom.sv
module pcr_geom #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           restart_i,
  input  logic           advance_i,
  input  logic [WW-1:0]  width_i,
  input  logic [HW-1:0]  height_i,
  output pcr_pkg::pos_t  pos_o
);
  import pcr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CXW = (CW + 1 > WW) ? CW + 1 : WW;
  localparam int RXW = (RW + 1 > HW) ? RW + 1 : HW;

  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [DEST_W-1:0] off_q, off_d;
  logic [CXW-1:0]    col_inc;
  logic [RXW-1:0]    row_inc;
  logic              last_col, last_row;
  logic [HW-1:0]     rev_row;

  assign col_inc = CXW'(col_q) + CXW'(1);
  assign row_inc = RXW'(row_q) + RXW'(1);
  assign last_col = col_inc >= CXW'(width_i);
  assign last_row = row_inc >= RXW'(height_i);
  assign rev_row = height_i - HW'(1) - HW'(row_q);

  assign pos_o.col_offset = off_q;
  assign pos_o.rev_row = DEST_W'(rev_row);
  assign pos_o.frame_end = last_col && last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    off_d = off_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
      off_d = '0;
    end else if (advance_i) begin
      if (last_col) begin
        col_d = '0;
        off_d = '0;
        row_d = last_row ? '0 : RW'(row_inc);
      end else begin
        col_d = CW'(col_inc);
        off_d = off_q + DEST_W'(height_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      off_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      off_q <= off_d;
    end
  end

`ifndef ASSERT_OFF
  a_offset_zero_at_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q == '0 |-> off_q == '0)
    else $error("column offset not zero at start of row");
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CXW'(col_q) < CXW'(width_i))
    else $error("column counter beyond frame width");
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RXW'(row_q) < RXW'(height_i))
    else $error("row counter beyond frame height");
`endif

endmodule

### rtl/core/pcr_convert.sv
module pcr_convert (
  input  logic [pcr_pkg::PIX_W-1:0] pixel_i,
  input  pcr_pkg::pix_fmt_e         fmt_i,
  output pcr_pkg::rgb_t             rgb_o
);
  import pcr_pkg::*;

  logic [4:0]  red5, blue5;
  logic [5:0]  green6;
  logic [12:0] red_prod, blue_prod;
  logic [13:0] green_prod;

  assign red5 = pixel_i[15:11];
  assign green6 = pixel_i[10:5];
  assign blue5 = pixel_i[4:0];

  // 255*c/32 and 255*c/64, the divide is a plain shift
  assign red_prod = 13'(red5) * 13'(FULL_SCALE);
  assign green_prod = 14'(green6) * 14'(FULL_SCALE);
  assign blue_prod = 13'(blue5) * 13'(FULL_SCALE);

  always_comb begin
    case (fmt_i)
      FMT_RGB565: begin
        rgb_o.b0 = red_prod[12:5];
        rgb_o.b1 = green_prod[13:6];
        rgb_o.b2 = blue_prod[12:5];
      end
      default: begin
        // packed and alpha formats: low three bytes, alpha dropped
        rgb_o.b0 = pixel_i[7:0];
        rgb_o.b1 = pixel_i[15:8];
        rgb_o.b2 = pixel_i[23:16];
      end
    endcase
  end

endmodule

### tb/sv/pixel_rotate_checker.sv
`timescale 1ns / 1ps

module pixel_rotate_checker #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [pcr_pkg::PIX_W-1:0]     pixel_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [pcr_pkg::DEST_W-1:0]    dest_index_i,
  input  logic [pcr_pkg::BYTE_W-1:0]    byte_zero_i,
  input  logic [pcr_pkg::BYTE_W-1:0]    byte_one_i,
  input  logic [pcr_pkg::BYTE_W-1:0]    byte_two_i,
  input  logic                          frame_end_i,
  output int                            mismatch_count_o,
  output int                            checked_count_o,
  output int                            pending_count_o
);
  import pcr_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [DEST_W-1:0] dest;
    rgb_t              rgb;
    logic              frame_end;
  } rotated_pixel_t;

  logic [CFG_W-1:0]  width_q;
  logic [CFG_W-1:0]  height_q;
  logic [1:0]        format_q;
  logic [10:0]       column_q;
  logic [10:0]       row_q;
  logic [DEST_W-1:0] offset_q;

  rotated_pixel_t expected_pixels[$];
  int mismatches;
  int checked;

  // zero acts as one, oversize saturates
  function automatic int clamp_size(logic [CFG_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic int differs(string field, int unsigned want, int unsigned got);
    if (want == got) return 0;
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rotated_pixel_t want;
    int w;
    int h;
    int scale;
    logic last_col;
    logic last_row;
    if (!rst_ni) begin
      width_q = FRAME_WIDTH_RST;
      height_q = FRAME_HEIGHT_RST;
      format_q = FMT_RGB565;
      column_q = '0;
      row_q = '0;
      offset_q = '0;
      expected_pixels.delete();
      mismatches = 0;
      checked = 0;
      mismatch_count_o <= 0;
      checked_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_WIDTH: begin
            width_q = cfg_data_i;
            column_q = '0;
            row_q = '0;
            offset_q = '0;
          end
          REG_FRAME_HEIGHT: begin
            height_q = cfg_data_i;
            column_q = '0;
            row_q = '0;
            offset_q = '0;
          end
          REG_PIXEL_FORMAT: format_q = cfg_data_i[1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        w = clamp_size(width_q, MAX_WIDTH);
        h = clamp_size(height_q, MAX_HEIGHT);
        scale = int'(FULL_SCALE);
        if (format_q == FMT_RGB565) begin
          want.rgb.b0 = BYTE_W'(scale * int'(pixel_word_i[15:11]) / 32);
          want.rgb.b1 = BYTE_W'(scale * int'(pixel_word_i[10:5]) / 64);
          want.rgb.b2 = BYTE_W'(scale * int'(pixel_word_i[4:0]) / 32);
        end else begin
          want.rgb.b0 = pixel_word_i[7:0];
          want.rgb.b1 = pixel_word_i[15:8];
          want.rgb.b2 = pixel_word_i[23:16];
        end
        want.dest = offset_q + DEST_W'(h - 1 - int'(row_q));
        last_col = (int'(column_q) + 1 >= w);
        last_row = (int'(row_q) + 1 >= h);
        want.frame_end = last_col && last_row;
        expected_pixels.push_back(want);
        if (last_col) begin
          column_q = '0;
          offset_q = '0;
          row_q = last_row ? '0 : row_q + 11'd1;
        end else begin
          column_q = column_q + 11'd1;
          offset_q = offset_q + DEST_W'(h);
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual dest 0x%0h",
                     $time, dest_index_i);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          mismatches += differs("dest_index", want.dest, dest_index_i);
          mismatches += differs("byte_zero", want.rgb.b0, byte_zero_i);
          mismatches += differs("byte_one", want.rgb.b1, byte_one_i);
          mismatches += differs("byte_two", want.rgb.b2, byte_two_i);
          mismatches += differs("frame_end", want.frame_end, frame_end_i);
          checked++;
        end
      end

      mismatch_count_o <= mismatches;
      checked_count_o <= checked;
      pending_count_o <= expected_pixels.size();
    end
  end

endmodule

### tb/sv/tb_pixel_convert_rotate90.sv
`timescale 1ns / 1ps

module tb_pixel_convert_rotate90;
  import pcr_pkg::*;

  localparam int MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT = 2048;

  // index 3 has no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // format code 3 is not in the enum, behaves like the 32-bit format
  localparam logic [1:0] FMT_SPARE = 2'd3;

  localparam int HOLD_CYCLES = 400;    // long receiver hold-off to back up the pipe
  localparam int SETTLE_CYCLES = 8;    // slack added after every result has come back
  localparam int IDLE_LIMIT = 4000;    // watchdog, well above the hold-off
  localparam int RANDOM_PHASES = 14;
  localparam int LONG_ROW = 300;       // row length for the full-rate run

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_word_i = '0;

  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DEST_W-1:0]    dest_index_o;
  logic [BYTE_W-1:0]    byte_zero_o;
  logic [BYTE_W-1:0]    byte_one_o;
  logic [BYTE_W-1:0]    byte_two_o;
  logic                 frame_end_o;

  // results from the checker
  int mismatch_count;
  int checked_count;
  int pending_count;

  // stimulus bookkeeping
  int pixels_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int input_stall_cycles = 0;

  // per-phase idling switches, and the one-shot request for a long hold-off
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit long_hold_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pixel_convert_rotate90 #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_word_i(pixel_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dest_index_o(dest_index_o),
    .byte_zero_o (byte_zero_o),
    .byte_one_o  (byte_one_o),
    .byte_two_o  (byte_two_o),
    .frame_end_o (frame_end_o)
  );

  // watches both channels and the config port, predicts and compares
  pixel_rotate_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .pixel_word_i    (pixel_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dest_index_i    (dest_index_o),
    .byte_zero_i     (byte_zero_o),
    .byte_one_i      (byte_one_o),
    .byte_two_i      (byte_two_o),
    .frame_end_i     (frame_end_o),
    .mismatch_count_o(mismatch_count),
    .checked_count_o (checked_count),
    .pending_count_o (pending_count)
  );

  // watchdog: any transaction or config write resets the idle count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (in_valid_i && in_stall_o)
        input_stall_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: random stall before each result while idling is enabled, a long hold-off on request
  initial begin : receiver
    int stall_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_idle_en) begin
        stall_len = $urandom_range(0, 7);
        if (stall_len > 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      // stall is low from here on, so the first edge with valid takes the result
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one pixel transaction; valid stays up across back-to-back pixels
  task automatic put_pixel(input logic [PIX_W-1:0] word);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  // write strobe is dropped between writes so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait until every pixel has come back, plus some slack
  task automatic settle();
    in_valid_i <= 1'b0;
    while (checked_count != pixels_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // frame size: mostly tiny so frames wrap often, sometimes the extremes
  function automatic logic [CFG_W-1:0] pick_dim(int limit);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(limit);
      3: return '1;
      4: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(2, 9));
    endcase
  endfunction

  initial begin : stimulus
    int count;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry 320x480, rgb565: channel extremes and ignored upper half
    put_pixel(32'h0000_0000);
    put_pixel(32'hFFFF_FFFF);
    put_pixel(32'h0000_F800);
    put_pixel(32'h0000_07E0);
    put_pixel(32'h0000_001F);
    put_pixel(32'hFFFF_0000);
    put_pixel(32'h0000_8410);
    settle();
    settings_used++;

    // packed 24-bit and 32-bit: alpha byte must be dropped
    write_reg(REG_PIXEL_FORMAT, CFG_W'(FMT_RGB888));
    put_pixel(32'hFF12_3456);
    put_pixel(32'h00AB_CDEF);
    settle();
    write_reg(REG_PIXEL_FORMAT, CFG_W'(FMT_ARGB));
    put_pixel(32'hFFFF_FFFF);
    put_pixel(32'h8000_0001);
    settle();
    // unnamed format code acts as 32-bit
    write_reg(REG_PIXEL_FORMAT, CFG_W'(FMT_SPARE));
    put_pixel(32'h7F80_01FE);
    settle();

    // zero size acts as 1x1: every pixel ends a frame
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    put_pixel(32'h1234_5678);
    put_pixel(32'h9ABC_DEF0);
    settle();

    // oversize saturates to the maximum frame
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, '1);
    put_pixel(32'h0F0F_0F0F);
    put_pixel(32'hF0F0_F0F0);
    settle();

    // 3x2 frame: a format write mid-frame keeps the raster position
    write_reg(REG_FRAME_WIDTH, CFG_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    write_reg(REG_PIXEL_FORMAT, CFG_W'(FMT_RGB565));
    put_pixel(32'h0000_FFFF);
    put_pixel(32'h0000_7BEF);
    settle();
    write_reg(REG_PIXEL_FORMAT, CFG_W'(FMT_RGB888));
    put_pixel(32'h0011_2233);
    put_pixel(32'h0044_5566);
    settle();
    // write to the unused index must not touch anything; run through frame end
    write_reg(REG_SPARE, '1);
    put_pixel(32'h0077_8899);
    put_pixel(32'h00AA_BBCC);
    put_pixel(32'h00DD_EEFF);
    settle();
    settings_used += 6;

    // random phases: new settings, random idling, occasional long hold-off
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case ($urandom_range(0, 5))
        // format only, the frame continues where it was
        0: write_reg(REG_PIXEL_FORMAT, CFG_W'($urandom_range(FMT_RGB565, FMT_SPARE)));
        1: begin
          write_reg(REG_SPARE, CFG_W'($urandom));
          write_reg(REG_PIXEL_FORMAT, CFG_W'($urandom_range(FMT_RGB565, FMT_SPARE)));
        end
        default: begin
          write_reg(REG_FRAME_WIDTH, pick_dim(MAX_WIDTH));
          write_reg(REG_FRAME_HEIGHT, pick_dim(MAX_HEIGHT));
          write_reg(REG_PIXEL_FORMAT, CFG_W'($urandom_range(FMT_RGB565, FMT_SPARE)));
        end
      endcase
      settings_used++;
      tx_idle_en = ($urandom_range(0, 2) != 0);
      rx_idle_en = ($urandom_range(0, 2) != 0);
      // sender keeps pushing while the receiver sits still, so the input stalls
      if (phase == 1 || $urandom_range(0, 7) == 0) begin
        tx_idle_en = 1'b0;
        long_hold_req = 1'b1;
      end
      count = $urandom_range(60, 160);
      repeat (count) put_pixel($urandom);
    end

    // tallest frame at full rate: one long row plus a few, so the row
    // wraps and the rotated index climbs high
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(LONG_ROW));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(MAX_HEIGHT));
    write_reg(REG_PIXEL_FORMAT, CFG_W'($urandom_range(FMT_RGB565, FMT_SPARE)));
    settings_used++;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (LONG_ROW + 8) put_pixel($urandom);

    settle();
    $display("covered %0d pixels over %0d settings, %0d results compared",
             pixels_sent, settings_used, checked_count);
    $display("all formats, frames from 1x1 to full size, input held back %0d cycles",
             input_stall_cycles);
    if (pending_count != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_count);
    if (mismatch_count == 0 && pending_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
